// ----- rtl/sdh_pkg.sv -----
// shared types and constants for the sd card spi host
`default_nettype none
package sdh_pkg;

  localparam int BlockBytes = 512;
  localparam int CountW = 10;

  typedef enum logic [2:0] {
    OP_INIT  = 3'd0,
    OP_READ  = 3'd1,
    OP_WRITE = 3'd2,
    OP_XFER  = 3'd3,
    OP_WDATA = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    K_XCHG  = 2'd0,
    K_RDATA = 2'd1,
    K_WWANT = 2'd2,
    K_DONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    CFG_POLL   = 3'd0,
    CFG_SD2    = 3'd1,
    CFG_LEGACY = 3'd2,
    CFG_TOKEN  = 3'd3,
    CFG_WAKE   = 3'd4
  } cfg_idx_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOIDL = 2'd1;
  localparam logic [1:0] ST_RDERR = 2'd2;
  localparam logic [1:0] ST_WRERR = 2'd3;

  // classified request from the front part
  typedef struct packed {
    op_t         op;
    logic [31:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  miso;
  } req_t;

  // one result item
  typedef struct packed {
    kind_t      kind;
    logic [7:0] mosi;
    logic       sel;
    logic       slow;
    logic [7:0] rbyte;
    logic [1:0] status;
    logic [2:0] ctype;
    logic       last;
  } res_t;

endpackage
`default_nettype wire

// ----- rtl/sdh_front.sv -----
// input stage and request queue in front of the sequencer
`default_nettype none
module sdh_front
  import sdh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  operation,
  input  wire logic [31:0] block_address,
  input  wire logic [7:0]  write_data,
  input  wire logic [7:0]  miso_byte,
  output logic             q_valid,
  input  wire logic        q_ready,
  output req_t             q_data
);

  req_t       mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] fill;
  logic       push;
  logic       pop;

  assign in_ready = (fill != 3'd4);
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != 3'd0);
  assign pop      = q_valid && q_ready;
  assign q_data   = mem[rd_ptr];

  // request storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{op: op_t'(operation), addr: block_address,
                       wdata: write_data, miso: miso_byte};
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + {2'b0, push} - {2'b0, pop};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sdh_back.sv -----
// command sequencer: turns requests into exchange and data results
`default_nettype none
module sdh_back
  import sdh_pkg::*;
#(
  parameter int BLOCK_BYTES = BlockBytes
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  req_t             q_data,
  input  wire logic [7:0]  poll_lim,
  input  wire logic [15:0] sd2_tries,
  input  wire logic [15:0] leg_tries,
  input  wire logic [15:0] tok_lim,
  input  wire logic [7:0]  wake_n,
  output logic             out_valid,
  input  wire logic        out_ready,
  output res_t             out_data,
  output logic             busy
);

  localparam int BcW = $clog2(BLOCK_BYTES + 1);

  typedef enum logic [4:0] {
    PH_IDLE, PH_WAKE, PH_CMD_OUT, PH_CMD_POLL, PH_REL0, PH_R7, PH_OCR,
    PH_RD_GAP, PH_RD_TOKEN, PH_RD_DATA, PH_RD_CRC, PH_WR_GAP, PH_WR_TOKEN,
    PH_WR_WAIT, PH_WR_DATA, PH_WR_CRC, PH_WR_RESP, PH_WR_BUSY
  } phase_t;

  typedef enum logic [3:0] {
    S_NONE, S_CMD0, S_CMD8, S_SD2, S_CMD58, S_PROBE, S_LEGACY, S_CMD16,
    S_CMD18, S_CMD12, S_CMD24
  } step_t;

  phase_t      phase, phase_next;
  step_t       step, step_next;
  logic [47:0] frame, frame_next;
  logic [BcW-1:0] bcnt, bcnt_next;
  logic [15:0] retry, retry_next;
  logic [7:0]  pcnt, pcnt_next;
  logic [31:0] reply, reply_next;
  logic [2:0]  dtype, dtype_next;
  logic        app, app_next;

  // two-entry result buffer
  res_t        rb0, rb1;
  logic [1:0]  rcnt;

  // results of the current request, built combinationally
  logic        e0_v, e1_v;
  kind_t       e0_k, e1_k;
  logic [7:0]  e0_m, e0_r;
  logic [1:0]  e1_s, e0_s;
  logic        e0_wake;

  logic [7:0]  m;
  logic [7:0]  plim;
  logic [15:0] tlim;
  logic [7:0]  cbyte;
  logic [47:0] cur_frame;
  logic [15:0] retry_dec;
  logic        fire;

  assign busy    = (phase != PH_IDLE) || (rcnt != 2'd0);
  // take a request when the buffer is empty or its only result leaves now
  assign q_ready = (rcnt == 2'd0) || ((rcnt == 2'd1) && out_ready);
  assign fire    = q_valid && q_ready;
  assign m       = q_data.miso;
  assign plim    = (poll_lim == 8'd0) ? 8'd1 : poll_lim;
  assign tlim    = (tok_lim == 16'd0) ? 16'd1 : tok_lim;
  assign retry_dec = retry - 16'd1;

  // frame byte for the current command position
  assign cur_frame = app ? 48'h770000000001 : frame;
  always_comb begin
    case (bcnt_next[2:0])
      3'd2: cbyte = cur_frame[47:40];
      3'd3: cbyte = cur_frame[39:32];
      3'd4: cbyte = cur_frame[31:24];
      3'd5: cbyte = cur_frame[23:16];
      3'd6: cbyte = cur_frame[15:8];
      3'd7: cbyte = cur_frame[7:0];
      default: cbyte = 8'hFF;
    endcase
  end

  // frame for a command index with argument
  function automatic logic [47:0] mk_frame(input logic [5:0] idx, input logic [31:0] arg);
    logic [7:0] crc;
    crc = (idx == 6'd0) ? 8'h95 : ((idx == 6'd8) ? 8'h87 : 8'h01);
    return {2'b01, idx, arg, crc};
  endfunction

  // next-state logic mirroring the byte sequencer
  always_comb begin
    phase_next = phase;
    step_next  = step;
    frame_next = frame;
    bcnt_next  = bcnt;
    retry_next = retry;
    pcnt_next  = pcnt;
    reply_next = reply;
    dtype_next = dtype;
    app_next   = app;
    e0_v = 1'b0; e1_v = 1'b0;
    e0_k = K_XCHG;
    e0_m = 8'hFF; e0_r = 8'h00; e0_s = ST_OK; e1_s = ST_OK;
    e0_wake = 1'b0;

    if (fire) begin
      case (q_data.op)
        OP_INIT, OP_READ, OP_WRITE: begin
          if (phase == PH_IDLE) begin
            e0_v = 1'b1;
            if (q_data.op == OP_INIT) begin
              dtype_next = '0;
              if (wake_n == 8'd0) begin
                frame_next = mk_frame(6'd0, 32'd0); app_next = 1'b0;
                step_next = S_CMD0; phase_next = PH_CMD_OUT; bcnt_next = '0;
              end else begin
                phase_next = PH_WAKE; bcnt_next = '0; e0_wake = 1'b1;
              end
            end else begin
              frame_next = mk_frame((q_data.op == OP_READ) ? 6'd18 : 6'd24, q_data.addr);
              app_next   = 1'b0;
              step_next  = (q_data.op == OP_READ) ? S_CMD18 : S_CMD24;
              phase_next = PH_CMD_OUT; bcnt_next = '0;
            end
          end
        end
        OP_WDATA: begin
          if (phase == PH_WR_WAIT) begin
            phase_next = PH_WR_DATA; e0_v = 1'b1; e0_m = q_data.wdata;
          end
        end
        OP_XFER: begin
          e0_v = (phase != PH_IDLE) && (phase != PH_WR_WAIT);
          case (phase)
            PH_WAKE: begin
              bcnt_next = bcnt + 1'b1;
              if ({{(16-BcW){1'b0}}, bcnt_next} >= {8'd0, wake_n}) begin
                frame_next = mk_frame(6'd0, 32'd0); app_next = 1'b0;
                step_next = S_CMD0; phase_next = PH_CMD_OUT; bcnt_next = '0;
              end else e0_wake = 1'b1;
            end
            PH_CMD_OUT: begin
              bcnt_next = bcnt + 1'b1;
              if (bcnt_next < BcW'(8)) e0_m = cbyte;
              else begin phase_next = PH_CMD_POLL; pcnt_next = '0; end
            end
            PH_CMD_POLL: begin
              pcnt_next = pcnt + 8'd1;
              if (!(m[7] && pcnt_next < plim)) begin
                if (app && m <= 8'd1) begin
                  app_next = 1'b0; phase_next = PH_CMD_OUT; bcnt_next = '0;
                end else begin
                  app_next = 1'b0;
                  case (step)
                    S_CMD0: begin
                      if (m == 8'd1) phase_next = PH_REL0;
                      else begin e0_k = K_DONE; e0_s = ST_NOIDL; end
                    end
                    S_CMD8: begin
                      phase_next = PH_CMD_OUT; bcnt_next = '0;
                      if (m == 8'd1) begin
                        phase_next = PH_R7; reply_next = '0;
                      end else begin
                        frame_next = mk_frame(6'd41, 32'd0); app_next = 1'b1;
                        step_next = S_PROBE;
                      end
                    end
                    S_SD2: begin
                      if (m != 8'd0) begin
                        retry_next = retry_dec;
                        if (retry_dec == 16'd0) e0_k = K_DONE;
                        else begin
                          frame_next = mk_frame(6'd41, 32'h40000000); app_next = 1'b1;
                          phase_next = PH_CMD_OUT; bcnt_next = '0;
                        end
                      end else begin
                        frame_next = mk_frame(6'd58, 32'd0); step_next = S_CMD58;
                        phase_next = PH_CMD_OUT; bcnt_next = '0;
                      end
                    end
                    S_CMD58: begin
                      if (m == 8'd0) begin
                        phase_next = PH_OCR; bcnt_next = '0; reply_next = '0;
                      end else e0_k = K_DONE;
                    end
                    S_PROBE: begin
                      retry_next = leg_tries;
                      if (leg_tries == 16'd0) begin
                        dtype_next = '0; e0_k = K_DONE;
                      end else begin
                        dtype_next = (m <= 8'd1) ? 3'd2 : 3'd1;
                        frame_next = mk_frame((m <= 8'd1) ? 6'd41 : 6'd1, 32'd0);
                        app_next = (m <= 8'd1); step_next = S_LEGACY;
                        phase_next = PH_CMD_OUT; bcnt_next = '0;
                      end
                    end
                    S_LEGACY: begin
                      if (m != 8'd0) begin
                        retry_next = retry_dec;
                        if (retry_dec == 16'd0) begin
                          dtype_next = '0; e0_k = K_DONE;
                        end else begin
                          frame_next = mk_frame((dtype == 3'd2) ? 6'd41 : 6'd1, 32'd0);
                          app_next = (dtype == 3'd2);
                          phase_next = PH_CMD_OUT; bcnt_next = '0;
                        end
                      end else begin
                        frame_next = mk_frame(6'd16, 32'(BLOCK_BYTES));
                        step_next = S_CMD16; phase_next = PH_CMD_OUT; bcnt_next = '0;
                      end
                    end
                    S_CMD16: begin
                      if (m != 8'd0) dtype_next = '0;
                      e0_k = K_DONE;
                    end
                    S_CMD18: begin
                      if (m != 8'd0) begin e0_k = K_DONE; e0_s = ST_RDERR; end
                      else phase_next = PH_RD_GAP;
                    end
                    S_CMD12: begin
                      phase_next = PH_RD_CRC; bcnt_next = '0;
                    end
                    S_CMD24: begin
                      if (m != 8'd0) begin e0_k = K_DONE; e0_s = ST_WRERR; end
                      else phase_next = PH_WR_GAP;
                    end
                    default: e0_k = K_DONE;
                  endcase
                end
              end
            end
            PH_REL0: begin
              frame_next = mk_frame(6'd8, 32'h1AA); app_next = 1'b0;
              step_next = S_CMD8; phase_next = PH_CMD_OUT; bcnt_next = '0;
            end
            PH_R7, PH_OCR: begin
              reply_next = {reply[23:0], m};
              bcnt_next = bcnt + 1'b1;
              if (bcnt_next >= BcW'(4)) begin
                if (phase == PH_OCR) begin
                  dtype_next = reply_next[30] ? 3'd4 : 3'd3;
                  e0_k = K_DONE;
                end else if (reply_next[15:0] == 16'h01AA && sd2_tries != 16'd0) begin
                  retry_next = sd2_tries;
                  frame_next = mk_frame(6'd41, 32'h40000000); app_next = 1'b1;
                  step_next = S_SD2; phase_next = PH_CMD_OUT; bcnt_next = '0;
                end else begin
                  if (reply_next[15:0] == 16'h01AA) retry_next = sd2_tries;
                  e0_k = K_DONE;
                end
              end
            end
            PH_RD_GAP: begin
              phase_next = PH_RD_TOKEN; retry_next = '0;
            end
            PH_RD_TOKEN: begin
              retry_next = retry + 16'd1;
              if (m == 8'hFE) begin
                phase_next = PH_RD_DATA; bcnt_next = '0;
              end else if (retry_next >= tlim) begin
                e0_k = K_DONE; e0_s = ST_RDERR;
              end
            end
            PH_RD_DATA: begin
              e0_k = K_RDATA; e0_r = m; e1_v = 1'b1;
              bcnt_next = bcnt + 1'b1;
              if (bcnt_next >= BcW'(BLOCK_BYTES)) begin
                frame_next = mk_frame(6'd12, 32'd0); app_next = 1'b0;
                step_next = S_CMD12; phase_next = PH_CMD_OUT; bcnt_next = '0;
              end
            end
            PH_RD_CRC: begin
              bcnt_next = bcnt + 1'b1;
              if (bcnt_next >= BcW'(2)) e0_k = K_DONE;
            end
            PH_WR_GAP: begin
              phase_next = PH_WR_TOKEN; e0_m = 8'hFE;
            end
            PH_WR_TOKEN: begin
              phase_next = PH_WR_WAIT; bcnt_next = '0; e0_k = K_WWANT;
            end
            PH_WR_DATA: begin
              bcnt_next = bcnt + 1'b1;
              if (bcnt_next < BcW'(BLOCK_BYTES)) begin
                phase_next = PH_WR_WAIT; e0_k = K_WWANT;
              end else begin
                phase_next = PH_WR_CRC; bcnt_next = '0;
              end
            end
            PH_WR_CRC: begin
              bcnt_next = bcnt + 1'b1;
              if (bcnt_next >= BcW'(2)) phase_next = PH_WR_RESP;
            end
            PH_WR_RESP: begin
              if (m[4:0] != 5'h05) begin e0_k = K_DONE; e0_s = ST_WRERR; end
              else begin phase_next = PH_WR_BUSY; retry_next = '0; end
            end
            PH_WR_BUSY: begin
              retry_next = retry + 16'd1;
              if (m == 8'hFF) e0_k = K_DONE;
              else if (retry_next >= tlim) begin e0_k = K_DONE; e0_s = ST_WRERR; end
            end
            default: e0_v = 1'b0;
          endcase
          if (e0_k == K_DONE) begin
            phase_next = PH_IDLE; step_next = S_NONE;
          end
        end
        default: ;
      endcase
    end
  end

  // second result only follows a read data byte: the next exchange or its command
  assign e1_k = K_XCHG;

  // state registers and result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      step  <= S_NONE;
      frame <= '0;
      bcnt  <= '0;
      retry <= '0;
      pcnt  <= '0;
      reply <= '0;
      dtype <= '0;
      app   <= 1'b0;
      rcnt  <= '0;
    end else begin
      phase <= phase_next;
      step  <= step_next;
      frame <= frame_next;
      bcnt  <= bcnt_next;
      retry <= retry_next;
      pcnt  <= pcnt_next;
      reply <= reply_next;
      dtype <= dtype_next;
      app   <= app_next;
      if (fire && e0_v) begin
        rcnt <= e1_v ? 2'd2 : 2'd1;
      end else if (out_valid && out_ready) begin
        rcnt <= rcnt - 2'd1;
      end
    end
  end

  // result payloads, second one moves up as the first drains
  always_ff @(posedge clk) begin
    if (fire && e0_v) begin
      rb0.kind   <= e0_k;
      rb0.mosi   <= (e0_k == K_XCHG) ? e0_m : 8'h00;
      rb0.sel    <= (e0_k == K_XCHG) && !e0_wake;
      rb0.slow   <= (e0_k == K_XCHG) && e0_wake;
      rb0.rbyte  <= (e0_k == K_RDATA) ? e0_r : 8'h00;
      rb0.status <= (e0_k == K_DONE) ? e0_s : 2'd0;
      rb0.ctype  <= (e0_k == K_RDATA) ? dtype : dtype_next;
      rb0.last   <= !e1_v;
      rb1.kind   <= e1_k;
      rb1.mosi   <= 8'hFF;
      rb1.sel    <= 1'b1;
      rb1.slow   <= 1'b0;
      rb1.rbyte  <= 8'h00;
      rb1.status <= e1_s;
      rb1.ctype  <= dtype_next;
      rb1.last   <= 1'b1;
    end else if (out_valid && out_ready) begin
      rb0 <= rb1;
    end
  end

  assign out_valid = (rcnt != 2'd0);
  assign out_data  = rb0;

endmodule
`default_nettype wire

// ----- rtl/sd_card_spi_host.sv -----
// Top level of the SPI-mode SD/MMC host sequencer. Requests (initialise,
// read a block, write a block), write data bytes and card bytes of finished
// exchanges enter a four-entry queue; a byte-level sequencer behind it issues
// exchange requests, read data bytes, write-byte requests and a final done
// with status and card type. The sequencer takes one item per clock while
// results are taken and its output buffer has room; an item that gives two
// results (a read data byte plus the next exchange) holds the queue while
// the two-entry output buffer drains. Configuration registers are written
// through their own port; the user must write them only while the block is
// idle, the block itself does not enforce this.
`default_nettype none
module sd_card_spi_host
  import sdh_pkg::*;
#(
  parameter int BLOCK_BYTES = BlockBytes
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  operation,
  input  wire logic [31:0] block_address,
  input  wire logic [7:0]  write_data,
  input  wire logic [7:0]  miso_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [7:0]       mosi_byte,
  output logic             card_select,
  output logic             slow_clock,
  output logic [7:0]       read_byte,
  output logic [1:0]       status,
  output logic [2:0]       card_type,
  output logic             last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic        q_valid;
  logic        q_ready;
  req_t        q_data;
  res_t        res;
  logic        busy;
  logic [7:0]  poll_lim;
  logic [15:0] sd2_tries;
  logic [15:0] leg_tries;
  logic [15:0] tok_lim;
  logic [7:0]  wake_n;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_lim  <= 8'd100;
      sd2_tries <= 16'd12000;
      leg_tries <= 16'd25000;
      tok_lim   <= 16'hFFFF;
      wake_n    <= 8'd10;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_POLL:   poll_lim  <= cfg_data[7:0];
        CFG_SD2:    sd2_tries <= cfg_data;
        CFG_LEGACY: leg_tries <= cfg_data;
        CFG_TOKEN:  tok_lim   <= cfg_data;
        CFG_WAKE:   wake_n    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  sdh_front u_front (
    .clk, .rst, .in_valid, .in_ready, .operation, .block_address,
    .write_data, .miso_byte, .q_valid, .q_ready, .q_data
  );

  sdh_back #(.BLOCK_BYTES(BLOCK_BYTES)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_data, .poll_lim, .sd2_tries,
    .leg_tries, .tok_lim, .wake_n, .out_valid, .out_ready,
    .out_data(res), .busy
  );

  assign kind        = res.kind;
  assign mosi_byte   = res.mosi;
  assign card_select = res.sel;
  assign slow_clock  = res.slow;
  assign read_byte   = res.rbyte;
  assign status      = res.status;
  assign card_type   = res.ctype;
  assign last        = res.last;

  // a wake exchange never has chip select
  assert property (@(posedge clk) disable iff (rst)
    out_valid && slow_clock |-> !card_select)
    else $error("slow exchange with card selected");

  // a done result is always the last of its request
  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == K_DONE |-> last)
    else $error("done result not marked last");

  // output stays busy while results wait
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> busy)
    else $error("result pending while idle");

endmodule
`default_nettype wire
